@@ src/bbce_pkg.sv @@
// shared constants and types of the blob centroid and extent unit
package bbce_pkg;

   localparam int DEF_MAX_DIM = 2048;
   localparam int CFG_W       = 12;
   localparam int OUT_W       = 11;
   localparam int CSR_IDX_W   = 4;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(1100);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(1100);

   typedef struct packed {
      logic busy;
      logic done;
   } bbce_div_status_type;

endpackage

@@ src/bbce_if.sv @@
// item channels and register write channel of the blob centroid and extent unit
interface bbce_req_if import bbce_pkg::*; ();
   logic valid;
   logic ready;
   logic pixel_set;

   modport source (output valid, output pixel_set, input ready);
   modport sink   (input valid, input pixel_set, output ready);
endinterface

interface bbce_rsp_if import bbce_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] center_x;
   logic [OUT_W-1:0] center_y;
   logic [OUT_W-1:0] radius;
   logic             frame_empty;

   modport source (output valid, output center_x, output center_y, output radius,
                   output frame_empty, input ready);
   modport sink   (input valid, input center_x, input center_y, input radius,
                   input frame_empty, output ready);
endinterface

interface bbce_csr_if import bbce_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/bbce_accum.sv @@
// raster position tracking and running sums, counts and maxima of set pixels
module bbce_accum import bbce_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM,
   localparam int POS_W = $clog2(MAX_DIM),
   localparam int CNT_W = 2 * POS_W + 1,
   localparam int SUM_W = 3 * POS_W + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             pixel_set,
   input  logic [CFG_W-1:0] frame_width,
   input  logic [CFG_W-1:0] frame_height,
   output logic             frame_end,
   output logic [SUM_W-1:0] sum_x_total,
   output logic [SUM_W-1:0] sum_y_total,
   output logic [CNT_W-1:0] count_total,
   output logic [POS_W-1:0] max_x_total,
   output logic [POS_W-1:0] max_y_total
);

   localparam logic [CFG_W:0] DIM_LIMIT = (CFG_W + 1)'(MAX_DIM);

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [SUM_W-1:0] sum_x_ff, sum_y_ff;
   logic [CNT_W-1:0] count_ff;
   logic [POS_W-1:0] max_x_ff, max_y_ff;
   logic [POS_W-1:0] last_col, last_row;
   logic [CFG_W:0]   width_ext, height_ext;
   logic             row_end;

   // last column and row index after clamping the size to 1..MAX_DIM
   always_comb begin
      width_ext  = {1'b0, frame_width};
      height_ext = {1'b0, frame_height};
      if (frame_width == '0) begin
         last_col = '0;
      end else if (width_ext > DIM_LIMIT) begin
         last_col = POS_W'(MAX_DIM - 1);
      end else begin
         last_col = POS_W'(width_ext - 1'b1);
      end
      if (frame_height == '0) begin
         last_row = '0;
      end else if (height_ext > DIM_LIMIT) begin
         last_row = POS_W'(MAX_DIM - 1);
      end else begin
         last_row = POS_W'(height_ext - 1'b1);
      end
   end

   assign row_end   = col_ff >= last_col;
   assign frame_end = row_end && (row_ff >= last_row);

   // totals including the pixel now offered
   always_comb begin
      sum_x_total = sum_x_ff;
      sum_y_total = sum_y_ff;
      count_total = count_ff;
      max_x_total = max_x_ff;
      max_y_total = max_y_ff;
      if (pixel_set) begin
         sum_x_total = sum_x_ff + SUM_W'(col_ff);
         sum_y_total = sum_y_ff + SUM_W'(row_ff);
         count_total = count_ff + 1'b1;
         if (col_ff > max_x_ff) begin
            max_x_total = col_ff;
         end
         if (row_ff > max_y_ff) begin
            max_y_total = row_ff;
         end
      end
   end

   always_comb begin
      col_in = col_ff + 1'b1;
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && frame_end)) begin
         col_ff   <= '0;
         row_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         count_ff <= '0;
         max_x_ff <= '0;
         max_y_ff <= '0;
      end else if (fire) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         sum_x_ff <= sum_x_total;
         sum_y_ff <= sum_y_total;
         count_ff <= count_total;
         max_x_ff <= max_x_total;
         max_y_ff <= max_y_total;
      end
   end

endmodule

@@ src/bbce_div.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit a position
module bbce_div import bbce_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM,
   localparam int POS_W = $clog2(MAX_DIM),
   localparam int CNT_W = 2 * POS_W + 1,
   localparam int SUM_W = 3 * POS_W + 1,
   localparam int STEP_W = $clog2(POS_W)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    dividend,
   input  logic [CNT_W-1:0]    divisor,
   output logic [POS_W-1:0]    quotient,
   output bbce_div_status_type status
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff, done_ff;
   logic [CNT_W:0]    rem_shift, diff;

   // quotient bits shift in at the bottom as dividend bits leave the top
   always_comb begin
      rem_shift = {rem_ff, quo_ff[POS_W-1]};
      diff      = rem_shift - {1'b0, div_ff};
      if (diff[CNT_W]) begin
         rem_in = rem_shift[CNT_W-1:0];
         quo_in = {quo_ff[POS_W-2:0], 1'b0};
      end else begin
         rem_in = diff[CNT_W-1:0];
         quo_in = {quo_ff[POS_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // high part of the dividend is below the divisor since the mean stays under MAX_DIM
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[SUM_W-1:POS_W];
         quo_ff <= dividend[POS_W-1:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ src/binary_blob_centroid_extent_unit.sv @@
// Binary blob centroid and extent unit.
// req_bus takes one binary pixel per item in raster order; the block counts
// column and row itself from the frame_width and frame_height registers,
// written over csr_bus (index 0 width, index 1 height, always ready).
// Ordinary pixels are taken one per cycle while the block is idle and give
// no result. The last pixel of a frame starts two divisions (sum of columns
// and of rows by the pixel count) on one shared restoring divider that makes
// one quotient bit a cycle; req_bus.ready stays low through both divisions
// and until the result is loaded into the rsp_bus output register.
// rsp_bus gives center_x, center_y, radius and frame_empty; an empty frame
// skips the divider and reports frame_empty with zero fields.
// While a result waits for rsp_bus.ready the block keeps taking pixels of the
// next frame; a second frame end's result waits until the register is free.
// Synchronous reset clears the running sums, position and pending result and
// sets both size registers to 1100.
module binary_blob_centroid_extent_unit import bbce_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM
) (
   input  logic       clock,
   input  logic       reset,
   bbce_req_if.sink   req_bus,
   bbce_rsp_if.source rsp_bus,
   bbce_csr_if.sink   csr_bus
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int CNT_W = 2 * POS_W + 1;
   localparam int SUM_W = 3 * POS_W + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIVX = 2'd1;
   localparam logic [1:0] ST_DIVY = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             req_fire, frame_end;
   logic [SUM_W-1:0] sum_x_total, sum_y_total;
   logic [CNT_W-1:0] count_total;
   logic [POS_W-1:0] max_x_total, max_y_total;

   logic [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic [POS_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic             empty_ff, empty_in;

   logic                div_start;
   logic [SUM_W-1:0]    div_dividend;
   logic [CNT_W-1:0]    div_divisor;
   logic [POS_W-1:0]    div_quotient;
   bbce_div_status_type div_status;

   logic             rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [OUT_W-1:0] rsp_cx_ff, rsp_cy_ff, rsp_rad_ff;
   logic             rsp_empty_ff;
   logic [POS_W-1:0] dx, dy, rad;
   logic [OUT_W+POS_W-1:0] cx_wide, cy_wide, rad_wide;

   assign req_bus.ready = state_ff == ST_IDLE;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_FRAME_WIDTH:  width_ff  <= csr_bus.data;
            REG_FRAME_HEIGHT: height_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   bbce_accum #(.MAX_DIM(MAX_DIM)) accum_inst (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .pixel_set   (req_bus.pixel_set),
      .frame_width (width_ff),
      .frame_height(height_ff),
      .frame_end   (frame_end),
      .sum_x_total (sum_x_total),
      .sum_y_total (sum_y_total),
      .count_total (count_total),
      .max_x_total (max_x_total),
      .max_y_total (max_y_total)
   );

   bbce_div #(.MAX_DIM(MAX_DIM)) div_inst (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_quotient),
      .status  (div_status)
   );

   // radius from the finished centroid; the mean never exceeds the maximum
   always_comb begin
      dx  = max_x_ff - cx_ff;
      dy  = max_y_ff - cy_ff;
      rad = (dx > dy) ? dx : dy;
      if (empty_ff) begin
         cx_wide  = '0;
         cy_wide  = '0;
         rad_wide = '0;
      end else begin
         cx_wide  = {{OUT_W{1'b0}}, cx_ff};
         cy_wide  = {{OUT_W{1'b0}}, cy_ff};
         rad_wide = {{OUT_W{1'b0}}, rad};
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_y_in     = sum_y_ff;
      count_in     = count_ff;
      max_x_in     = max_x_ff;
      max_y_in     = max_y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      empty_in     = empty_ff;
      div_start    = 1'b0;
      div_dividend = sum_y_ff;
      div_divisor  = count_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            div_dividend = sum_x_total;
            div_divisor  = count_total;
            if (req_fire && frame_end) begin
               sum_y_in = sum_y_total;
               count_in = count_total;
               max_x_in = max_x_total;
               max_y_in = max_y_total;
               if (count_total == '0) begin
                  empty_in = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  empty_in  = 1'b0;
                  div_start = 1'b1;
                  state_in  = ST_DIVX;
               end
            end
         end
         ST_DIVX: begin
            if (div_status.done) begin
               cx_in     = div_quotient;
               div_start = 1'b1;
               state_in  = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_status.done) begin
               cy_in    = div_quotient;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_y_ff <= sum_y_in;
      count_ff <= count_in;
      max_x_ff <= max_x_in;
      max_y_ff <= max_y_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      empty_ff <= empty_in;
      if (rsp_load) begin
         rsp_cx_ff    <= cx_wide[OUT_W-1:0];
         rsp_cy_ff    <= cy_wide[OUT_W-1:0];
         rsp_rad_ff   <= rad_wide[OUT_W-1:0];
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.center_x    = rsp_cx_ff;
   assign rsp_bus.center_y    = rsp_cy_ff;
   assign rsp_bus.radius      = rsp_rad_ff;
   assign rsp_bus.frame_empty = rsp_empty_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVX || state_ff == ST_DIVY))
      else $error("divider finished outside a division step");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result raised without a finished frame");

   a_mean_below_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !empty_ff) |-> (cx_ff <= max_x_ff && cy_ff <= max_y_ff))
      else $error("centroid beyond largest position");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |->
         (rsp_cx_ff == '0 && rsp_cy_ff == '0 && rsp_rad_ff == '0))
      else $error("empty frame with nonzero fields");

   a_no_div_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN || state_ff == ST_IDLE) |-> !div_status.busy)
      else $error("divider busy outside a division step");

endmodule
